### hdl/crtf_pkg.sv
// Package for the capture record type filter.
// Holds the record layout constants, phase and result codes and the queue entry type.
// No dependencies.
package crtf_pkg;

    // Record header layout
    localparam int unsigned HDR_LEN   = 20;
    localparam int unsigned DELIM_LEN = 4;
    localparam int unsigned LEN_START = 12;

    localparam int unsigned TYPE_W = 27;

    // Delimiter characters, in stream order
    localparam logic [7:0] DELIM_CHARS [DELIM_LEN] = '{8'h40, 8'h52, 8'h44, 8'h43};

    // Parser phase codes
    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_PAYLOAD  = 2'd1;
    localparam logic [1:0] PH_BADDELIM = 2'd2;
    localparam logic [1:0] PH_TRUNC    = 2'd3;

    // Result kind codes
    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_REPORT   = 3'd1;
    localparam logic [2:0] KIND_DONE     = 3'd2;
    localparam logic [2:0] KIND_BADDELIM = 3'd3;
    localparam logic [2:0] KIND_TRUNC    = 3'd4;

    // Work item passed from the parser to the output stage
    typedef struct packed {
        logic              emit;       // produces a result transaction
        logic              rec_inc;    // bump record count
        logic              byte_inc;   // bump byte count
        logic [2:0]        kind;
        logic [7:0]        payload_byte;
        logic [TYPE_W-1:0] message_type;
        logic              record_end;
    } t_entry;

    // Queue status seen by the output stage
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

### hdl/crtf_if.sv
// Channel interfaces for the capture record type filter: input bytes, results, config.
// No dependencies.
interface crtf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface crtf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [26:0] message_type;
    logic        record_end;
    logic [31:0] records_captured;
    logic [31:0] bytes_captured;

    modport source (output valid, output kind, output payload_byte, output message_type,
                    output record_end, output records_captured, output bytes_captured,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input message_type,
                    input record_end, input records_captured, input bytes_captured,
                    output ready);
endinterface

interface crtf_cfg_if;
    logic        valid;
    logic        ready;
    logic [26:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/crtf_front.sv
// Parser front end: takes stream bytes, tracks headers and payload, classifies each
// byte into a queue entry. Holds the wanted type register. Depends on crtf_pkg, crtf_if.
module crtf_front
    import crtf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    crtf_in_if.sink         i_in,
    crtf_cfg_if.sink        i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output t_entry          o_entry
);

    logic [TYPE_W-1:0] r_wanted;
    logic [1:0]        r_phase,  n_phase;
    logic [4:0]        r_hpos,   n_hpos;
    logic              r_dgood,  n_dgood;
    logic [TYPE_W-1:0] r_type,   n_type;
    logic              r_tstop,  n_tstop;
    logic [TYPE_W-1:0] r_len,    n_len;
    logic              r_lstop,  n_lstop;
    logic [TYPE_W-1:0] r_left,   n_left;
    logic              r_sel,    n_sel;

    logic       accept;
    logic [7:0] b;
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
    logic       sel;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && !i_q_full;
    assign b           = i_in.data_byte;
    assign is_digit    = (b >= 8'h30) && (b <= 8'h39);
    assign digit       = b[3:0];

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= '0;
        end else if (i_cfg.valid) begin
            r_wanted <= i_cfg.data;
        end
    end

    // Classify one transaction
    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_dgood = r_dgood;
        n_type  = r_type;
        n_tstop = r_tstop;
        n_len   = r_len;
        n_lstop = r_lstop;
        n_left  = r_left;
        n_sel   = r_sel;
        o_push  = 1'b0;
        o_entry = '0;
        last    = (r_left == TYPE_W'(1));
        sel     = 1'b0;
        if (accept) begin
            if (i_in.end_of_stream) begin
                o_push       = 1'b1;
                o_entry.emit = 1'b1;
                case (r_phase)
                    PH_BADDELIM: o_entry.kind = KIND_BADDELIM;
                    PH_TRUNC:    o_entry.kind = KIND_TRUNC;
                    default: begin
                        if (r_phase == PH_HEADER && r_hpos == '0) begin
                            o_entry.kind = KIND_DONE;
                        end else begin
                            o_entry.kind = KIND_TRUNC;
                            n_phase      = PH_TRUNC;
                        end
                    end
                endcase
            end else if (r_phase == PH_PAYLOAD) begin
                n_left = r_left - TYPE_W'(1);
                if (last) begin
                    n_phase = PH_HEADER;
                end
                if (r_wanted == '0) begin
                    if (last) begin
                        o_push               = 1'b1;
                        o_entry.emit         = 1'b1;
                        o_entry.rec_inc      = 1'b1;
                        o_entry.kind         = KIND_REPORT;
                        o_entry.message_type = r_type;
                    end
                end else if (r_sel) begin
                    o_push               = 1'b1;
                    o_entry.emit         = 1'b1;
                    o_entry.byte_inc     = 1'b1;
                    o_entry.rec_inc      = last;
                    o_entry.kind         = KIND_PAYLOAD;
                    o_entry.payload_byte = b;
                    o_entry.message_type = r_type;
                    o_entry.record_end   = last;
                end
            end else if (r_phase == PH_HEADER) begin
                // a new header starts from cleared fields
                if (r_hpos == '0) begin
                    n_dgood = 1'b1;
                    n_type  = '0;
                    n_tstop = 1'b0;
                    n_len   = '0;
                    n_lstop = 1'b0;
                end
                if (r_hpos < 5'(DELIM_LEN)) begin
                    if (b != DELIM_CHARS[r_hpos[1:0]]) begin
                        n_dgood = 1'b0;
                    end
                end else if (r_hpos < 5'(LEN_START)) begin
                    if (!n_tstop) begin
                        if (is_digit) begin
                            n_type = (n_type << 3) + (n_type << 1) + TYPE_W'(digit);
                        end else begin
                            n_tstop = 1'b1;
                        end
                    end
                end else begin
                    if (!n_lstop) begin
                        if (is_digit) begin
                            n_len = (n_len << 3) + (n_len << 1) + TYPE_W'(digit);
                        end else begin
                            n_lstop = 1'b1;
                        end
                    end
                end
                // header complete
                if (r_hpos == 5'(HDR_LEN - 1)) begin
                    n_hpos = '0;
                    if (!n_dgood) begin
                        n_phase      = PH_BADDELIM;
                        o_push       = 1'b1;
                        o_entry.emit = 1'b1;
                        o_entry.kind = KIND_BADDELIM;
                    end else begin
                        sel    = (r_wanted != '0) && (n_type == r_wanted);
                        n_sel  = sel;
                        n_left = n_len;
                        if (n_len != '0) begin
                            n_phase = PH_PAYLOAD;
                        end else if (r_wanted == '0) begin
                            o_push               = 1'b1;
                            o_entry.emit         = 1'b1;
                            o_entry.rec_inc      = 1'b1;
                            o_entry.kind         = KIND_REPORT;
                            o_entry.message_type = n_type;
                        end else if (sel) begin
                            // matched empty record: counted, nothing shown
                            o_push          = 1'b1;
                            o_entry.rec_inc = 1'b1;
                        end
                    end
                end else begin
                    n_hpos = r_hpos + 5'd1;
                end
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hpos  <= '0;
            r_dgood <= 1'b1;
            r_type  <= '0;
            r_tstop <= 1'b0;
            r_len   <= '0;
            r_lstop <= 1'b0;
            r_left  <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_dgood <= n_dgood;
            r_type  <= n_type;
            r_tstop <= n_tstop;
            r_len   <= n_len;
            r_lstop <= n_lstop;
            r_left  <= n_left;
            r_sel   <= n_sel;
        end
    end

    // Checks
    a_hpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hpos < 5'(HDR_LEN))
        else $error("header position out of range");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != '0)
        else $error("payload phase with nothing left");

    // truncation may freeze the header position mid-header; the other phases start at zero
    a_hpos_zero_outside_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_BADDELIM) |-> r_hpos == '0)
        else $error("header position left mid-header outside header phase");

endmodule

### hdl/crtf_fifo.sv
// Short queue of classified entries between parser and output stage.
// Depends on crtf_pkg.
module crtf_fifo
    import crtf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_cnt;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_head         = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (PTR_W+1)'(1);
            end
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty queue");

    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W+1)'(DEPTH))
        else $error("queue level out of range");

endmodule

### hdl/crtf_back.sv
// Output stage: applies queue entries to the saturating counters and drives
// the registered result channel. Depends on crtf_pkg, crtf_if.
module crtf_back
    import crtf_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  t_q_status  i_status,
    output logic       o_pop,
    crtf_out_if.source o_out
);

    logic [COUNT_WIDTH-1:0] r_rec_cnt, n_rec_cnt;
    logic [COUNT_WIDTH-1:0] r_byte_cnt, n_byte_cnt;
    logic                   r_valid;
    logic [2:0]             r_kind;
    logic [7:0]             r_pbyte;
    logic [TYPE_W-1:0]      r_mtype;
    logic                   r_rend;

    // Take the head when the output register is free or being drained
    assign o_pop = !i_status.empty && (!r_valid || o_out.ready);

    // Saturating counter updates
    always_comb begin
        n_rec_cnt  = r_rec_cnt;
        n_byte_cnt = r_byte_cnt;
        if (o_pop && i_head.rec_inc && r_rec_cnt != '1) begin
            n_rec_cnt = r_rec_cnt + COUNT_WIDTH'(1);
        end
        if (o_pop && i_head.byte_inc && r_byte_cnt != '1) begin
            n_byte_cnt = r_byte_cnt + COUNT_WIDTH'(1);
        end
    end

    // Counters and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_cnt  <= '0;
            r_byte_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_rec_cnt  <= n_rec_cnt;
            r_byte_cnt <= n_byte_cnt;
            if (o_pop) begin
                r_valid <= i_head.emit;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.emit) begin
            r_kind  <= i_head.kind;
            r_pbyte <= i_head.payload_byte;
            r_mtype <= i_head.message_type;
            r_rend  <= i_head.record_end;
            o_out.records_captured <= 32'(n_rec_cnt);
            o_out.bytes_captured   <= 32'(n_byte_cnt);
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_kind;
    assign o_out.payload_byte = r_pbyte;
    assign o_out.message_type = r_mtype;
    assign o_out.record_end   = r_rend;

    // Checks
    a_rec_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_rec_cnt >= $past(r_rec_cnt))
        else $error("record count went down");

    a_byte_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_byte_cnt >= $past(r_byte_cnt))
        else $error("byte count went down");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !o_out.ready |-> !o_pop)
        else $error("result overwritten while stalled");

endmodule

### hdl/capture_record_type_filter_core.sv
// Top level of the capture record type filter: parser, entry queue, output stage.
// Depends on crtf_pkg, crtf_if, crtf_front, crtf_fifo, crtf_back.
//
//   channel   dir   payload                                     transaction when
//   i_in      in    data_byte, end_of_stream                    valid && ready
//   o_out     out   kind, payload_byte, message_type,           valid && ready
//                   record_end, records_captured, bytes_captured
//   i_cfg     in    data (wanted type)                          valid && ready
//
// One byte per cycle while the queue is not full; each result is classified
// combinationally, held in the entry queue, then in the output register.
// The four-entry queue absorbs output stalls; i_in.ready drops only when it is full.
// Reset is synchronous, active low; it clears all parser state, counts and the
// wanted type. Bytes without a result also wait while the queue is full.
module capture_record_type_filter_core
    import crtf_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crtf_in_if.sink     i_in,
    crtf_cfg_if.sink    i_cfg,
    crtf_out_if.source  o_out
);

    logic      push;
    logic      pop;
    t_entry    entry;
    t_entry    head;
    t_q_status q_status;

    crtf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_status.full),
        .o_push   (push),
        .o_entry  (entry)
    );

    crtf_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    crtf_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_status),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

### test/tb.sv
// Testbench for capture_record_type_filter_core: a directed table, then random record streams.
// Results are checked against a cycle-free predictor of the record parser and filter.
// Depends on crtf_pkg, the crtf_if interfaces and the core RTL.
module tb;
    import crtf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int LONG_HOLD      = 300;
    localparam int FIELD_LEN      = 8;

    // One result transaction as seen on o_out
    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        pb;
        logic [TYPE_W-1:0] mt;
        logic              rend;
        logic [31:0]       recs;
        logic [31:0]       bytes;
    } t_result;

    // Directed stimulus row; want is used only when typed is set
    typedef struct {
        logic [7:0] b;
        bit         eos;
        bit         typed;
        t_result    want;
    } t_stim_row;

    typedef enum {END_BAD_DELIM, END_CUT_HEADER, END_CUT_PAYLOAD} t_ending;

    logic clk;
    logic rst_n;

    crtf_in_if  in_ch ();
    crtf_cfg_if cfg_ch ();
    crtf_out_if out_ch ();

    capture_record_type_filter_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Predictor state, at its reset values
    logic [TYPE_W-1:0] wanted_q  = '0;
    logic [1:0]        ph_q      = PH_HEADER;
    int unsigned       hdr_pos   = 0;
    bit                delim_ok  = 1'b1;
    logic [TYPE_W-1:0] type_acc  = '0;
    bit                type_stop = 1'b0;
    logic [TYPE_W-1:0] len_acc   = '0;
    bit                len_stop  = 1'b0;
    logic [TYPE_W-1:0] left_q    = '0;
    bit                selected  = 1'b0;
    logic [31:0]       rec_cnt   = '0;
    logic [31:0]       byte_cnt  = '0;

    t_result     pending_results[$];
    t_stim_row   directed_rows[$];
    logic [7:0]  rec_bytes[$];
    int          error_count   = 0;
    int unsigned items_sent    = 0;
    int          idle_cycles   = 0;
    bit          tx_steady     = 1'b0;
    bit          long_hold_req = 1'b0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic t_result make_result(logic [2:0] kind, logic [7:0] pb,
                                            logic [TYPE_W-1:0] mt, logic rend);
        t_result m;
        m.kind  = kind;
        m.pb    = pb;
        m.mt    = mt;
        m.rend  = rend;
        m.recs  = rec_cnt;
        m.bytes = byte_cnt;
        return m;
    endfunction

    // Leading-digit decimal accumulation, stops at the first non-digit
    function automatic void digit_step(inout logic [TYPE_W-1:0] acc, inout bit stopped,
                                       input logic [7:0] b);
        if (stopped)
            return;
        if (b >= 8'h30 && b <= 8'h39)
            acc = acc * 27'd10 + 27'(b[3:0]);
        else
            stopped = 1'b1;
    endfunction

    // Advance the filter by one input transaction; returns 1 when a result is due
    function automatic bit filter_step(input logic [7:0] b, input bit eos, output t_result r);
        bit last;
        r = '0;
        // sticky error phases only answer end of stream
        if (ph_q == PH_BADDELIM || ph_q == PH_TRUNC) begin
            if (!eos)
                return 1'b0;
            r = make_result(ph_q == PH_BADDELIM ? KIND_BADDELIM : KIND_TRUNC, 8'h00, '0, 1'b0);
            return 1'b1;
        end
        if (eos) begin
            if (ph_q == PH_HEADER && hdr_pos == 0) begin
                r = make_result(KIND_DONE, 8'h00, '0, 1'b0);
                return 1'b1;
            end
            ph_q = PH_TRUNC;
            r = make_result(KIND_TRUNC, 8'h00, '0, 1'b0);
            return 1'b1;
        end
        // payload
        if (ph_q == PH_PAYLOAD) begin
            last = (left_q == 27'd1);
            left_q = left_q - 27'd1;
            if (last)
                ph_q = PH_HEADER;
            if (wanted_q == '0) begin
                if (!last)
                    return 1'b0;
                rec_cnt = sat_inc(rec_cnt);
                r = make_result(KIND_REPORT, 8'h00, type_acc, 1'b0);
                return 1'b1;
            end
            if (!selected)
                return 1'b0;
            byte_cnt = sat_inc(byte_cnt);
            if (last)
                rec_cnt = sat_inc(rec_cnt);
            r = make_result(KIND_PAYLOAD, b, type_acc, last);
            return 1'b1;
        end
        // header
        if (hdr_pos == 0) begin
            delim_ok  = 1'b1;
            type_acc  = '0;
            type_stop = 1'b0;
            len_acc   = '0;
            len_stop  = 1'b0;
        end
        if (hdr_pos < DELIM_LEN) begin
            if (b != DELIM_CHARS[hdr_pos])
                delim_ok = 1'b0;
        end else if (hdr_pos < LEN_START) begin
            digit_step(type_acc, type_stop, b);
        end else begin
            digit_step(len_acc, len_stop, b);
        end
        hdr_pos++;
        if (hdr_pos < HDR_LEN)
            return 1'b0;
        hdr_pos = 0;
        if (!delim_ok) begin
            ph_q = PH_BADDELIM;
            r = make_result(KIND_BADDELIM, 8'h00, '0, 1'b0);
            return 1'b1;
        end
        selected = (wanted_q != '0) && (type_acc == wanted_q);
        left_q = len_acc;
        if (left_q != '0) begin
            ph_q = PH_PAYLOAD;
            return 1'b0;
        end
        ph_q = PH_HEADER;
        if (wanted_q == '0) begin
            rec_cnt = sat_inc(rec_cnt);
            r = make_result(KIND_REPORT, 8'h00, type_acc, 1'b0);
            return 1'b1;
        end
        if (selected)
            rec_cnt = sat_inc(rec_cnt);
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_nondigit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= 8'h30 && b <= 8'h39);
        return b;
    endfunction

    // Append one 8-byte decimal field in a randomly chosen layout
    function automatic void push_decimal(int unsigned v, bit allow_garbage);
        string s;
        int    mode;
        int    start;
        int    i;
        start = rec_bytes.size();
        mode  = $urandom_range(0, allow_garbage ? 3 : 2);
        s     = $sformatf("%0d", v);
        if (mode == 3) begin
            // arbitrary bytes; the predictor works out the value
            for (i = 0; i < FIELD_LEN; i++)
                rec_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (mode == 2 && v == 0) begin
            rec_bytes.push_back(rand_nondigit());
        end else if (mode == 1 && s.len() < FIELD_LEN) begin
            // short digits, terminator, then filler that must be ignored
            for (i = 0; i < s.len(); i++)
                rec_bytes.push_back(s[i]);
            rec_bytes.push_back(rand_nondigit());
        end else begin
            s = $sformatf("%08d", v);
            for (i = 0; i < FIELD_LEN; i++)
                rec_bytes.push_back(s[i]);
        end
        while (rec_bytes.size() - start < FIELD_LEN)
            rec_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic int unsigned pick_type(logic [TYPE_W-1:0] wanted);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && wanted != '0 && wanted <= 27'd99999999)
            return wanted;
        if (r < 60)
            return 0;
        if (r < 70)
            return 99999999;
        if (r < 85)
            return $urandom_range(1, 20);
        return $urandom_range(0, 99999999);
    endfunction

    function automatic int unsigned pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 30);
        return $urandom_range(31, 100);
    endfunction

    function automatic void add_row(logic [7:0] b, bit eos, bit typed, t_result want);
        t_stim_row row;
        row.b     = b;
        row.eos   = eos;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // One input transaction; the expectation is queued at the accepting edge
    task automatic send_item(input logic [7:0] b, input bit eos, input bit typed,
                             input t_result typed_r);
        int      gap;
        bit      has;
        t_result r;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk) in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.end_of_stream <= eos;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        has = filter_step(b, eos, r);
        if (typed) begin
            has = 1'b1;
            r   = typed_r;
        end
        if (has)
            pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic send_eos();
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    endtask

    // Stop sending and wait out every outstanding result plus pipeline latency
    task automatic drain_results();
        @(negedge clk) in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_wanted(input logic [TYPE_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        wanted_q = v;
        @(negedge clk) cfg_ch.valid <= 1'b0;
    endtask

    // Build a record and send it; bad_pos corrupts a delimiter byte, cut_at ends the
    // stream before that byte
    task automatic send_record(input int unsigned type_v, input int unsigned len_v,
                               input int bad_pos, input int cut_at);
        int i;
        rec_bytes.delete();
        for (i = 0; i < DELIM_LEN; i++)
            rec_bytes.push_back(DELIM_CHARS[i]);
        push_decimal(type_v, 1'b1);
        push_decimal(len_v, 1'b0);
        repeat (len_v) rec_bytes.push_back(8'($urandom_range(0, 255)));
        if (bad_pos >= 0)
            rec_bytes[bad_pos] = rec_bytes[bad_pos] ^ 8'($urandom_range(1, 255));
        tx_steady = ($urandom_range(0, 3) == 0);
        for (i = 0; i < rec_bytes.size() && (cut_at < 0 || i < cut_at); i++)
            send_item(rec_bytes[i], 1'b0, 1'b0, '0);
        if (cut_at >= 0)
            send_eos();
    endtask

    task automatic run_phase(input logic [TYPE_W-1:0] wanted, input int unsigned n);
        int unsigned start;
        set_wanted(wanted);
        start = items_sent;
        while (items_sent - start < n) begin
            send_record(pick_type(wanted), pick_len(), -1, -1);
            if ($urandom_range(0, 9) == 0)
                send_eos();
        end
    endtask

    // Stimulus
    initial begin
        string       type_txt;
        int          i;
        t_ending     ending;
        int unsigned len_v;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'h00;
        in_ch.end_of_stream = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        rst_n               = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        set_wanted('0);

        // Directed: done on an empty stream, then a zero-length record with the largest
        // type whose length field stops after one digit, then done again
        type_txt = "99999999";
        add_row(8'h00, 1'b1, 1'b1, '{KIND_DONE, 8'h00, 27'd0, 1'b0, 32'd0, 32'd0});
        for (i = 0; i < DELIM_LEN; i++)
            add_row(DELIM_CHARS[i], 1'b0, 1'b0, '0);
        for (i = 0; i < FIELD_LEN; i++)
            add_row(type_txt[i], 1'b0, 1'b0, '0);
        add_row(8'h30, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        for (i = 0; i < 4; i++)
            add_row(8'h39, 1'b0, 1'b0, '0);
        add_row(8'h39, 1'b0, 1'b1, '{KIND_REPORT, 8'h00, 27'd99999999, 1'b0, 32'd1, 32'd0});
        add_row(8'hA5, 1'b1, 1'b1, '{KIND_DONE, 8'h00, 27'd0, 1'b0, 32'd1, 32'd0});
        foreach (directed_rows[k])
            send_item(directed_rows[k].b, directed_rows[k].eos, directed_rows[k].typed,
                      directed_rows[k].want);

        // Random record streams under several wanted types
        long_hold_req = 1'b1;
        run_phase('0, 170);
        run_phase(27'd99999999, 160);
        run_phase(27'h7FFFFFF, 120);
        run_phase(27'($urandom_range(1, 20)), 170);
        run_phase('0, 150);
        run_phase(27'd1, 150);

        // Errors are sticky and reset is not repeated, so exactly one error ends the run
        ending = t_ending'($urandom_range(0, 2));
        len_v  = $urandom_range(3, 12);
        case (ending)
            END_BAD_DELIM: begin
                send_record(pick_type(wanted_q), len_v, $urandom_range(0, DELIM_LEN - 1), -1);
            end
            END_CUT_HEADER: begin
                send_record(pick_type(wanted_q), len_v, -1, $urandom_range(1, HDR_LEN - 1));
            end
            default: begin
                send_record(pick_type(wanted_q), len_v, -1,
                            HDR_LEN + $urandom_range(1, len_v - 1));
            end
        endcase
        // bytes after the error are ignored, each end of stream repeats the error
        repeat (8) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);

        drain_results();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Result receiver: random stalls, quiet stretches, and one long hold-off
    initial begin
        int r;
        int steady_left;
        int n;
        steady_left  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req && out_ch.valid) begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else if (steady_left > 0) begin
                steady_left--;
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    n = $urandom_range(8, 40);
                    out_ch.ready <= 1'b0;
                    repeat (n - 1) @(negedge clk);
                end else if (r < 5) begin
                    steady_left = $urandom_range(20, 100);
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= (r >= 30);
                end
            end
        end
    end

    // Result checker
    always @(posedge clk) begin
        t_result exp_r;
        if (out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result transaction, kind %0d", $time, out_ch.kind);
            end else begin
                exp_r = pending_results.pop_front();
                check_field("kind", exp_r.kind, out_ch.kind);
                check_field("payload_byte", exp_r.pb, out_ch.payload_byte);
                check_field("message_type", exp_r.mt, out_ch.message_type);
                check_field("record_end", exp_r.rend, out_ch.record_end);
                check_field("records_captured", exp_r.recs, out_ch.records_captured);
                check_field("bytes_captured", exp_r.bytes, out_ch.bytes_captured);
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
